// ----- rtl/srm_pkg.sv -----
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants of the stroke rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

  localparam int unsigned RateW  = 24;
  localparam int unsigned CountW = 16;
  localparam int unsigned TicksW = 16;
  localparam int unsigned ModeW  = 2;

  // strokes/min * 256 = 60000 ms * 256 / interval
  localparam logic [RateW-1:0]  RateNumerator = 24'd15360000;
  localparam logic [TicksW-1:0] TimeoutReset  = 16'd15000;
  localparam logic [TicksW-1:0] TicksMax      = 16'hFFFF;

  localparam logic [ModeW-1:0] ModeOff     = 2'd0;
  localparam logic [ModeW-1:0] ModeRunning = 2'd1;
  localparam logic [ModeW-1:0] ModePaused  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } srm_state_e;

endpackage

`default_nettype wire

// ----- rtl/srm_div.sv -----
// ----------------------------------------------------------------------------
// srm_div
// Restoring serial divider: fixed rate numerator over a 16-bit interval,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_div
  import srm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [TicksW-1:0] divisor_i,
  output logic                   done_o,
  output logic [RateW-1:0]       quotient_o
);

  localparam int unsigned CntW = $clog2(RateW);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TicksW-1:0] rem_q, rem_d;
  logic [RateW-1:0]  quo_q, quo_d;
  logic [TicksW-1:0] dvs_q, dvs_d;
  logic [TicksW:0]   shifted;
  logic [TicksW-1:0] diff;
  logic              fits;

  assign shifted = {rem_q, quo_q[RateW-1]};
  // only taken when it fits, and then the difference is below the divisor
  assign diff    = shifted[TicksW-1:0] - dvs_q;
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(RateW - 1);
      rem_d  = '0;
      quo_d  = RateNumerator;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits the divisor width
      rem_d = fits ? diff : shifted[TicksW-1:0];
      quo_d = {quo_q[RateW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quotient_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

`default_nettype wire

// ----- rtl/stroke_rate_meter.sv -----
// ----------------------------------------------------------------------------
// stroke_rate_meter
// Stroke rate tachometer with inactivity timeout, one input word per tick.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    button_level_i
//   out      output     out_valid_o / out_stall_i  stroke_rate_o, stroke_count_o,
//                                                  meter_mode_o
//   cfg      input      cfg_we_i                   cfg_wdata_i (timeout_ticks)
//
// A word without a new rate goes straight to the output register; a counted stroke
// with a previous stroke runs the serial divider (one quotient bit a cycle).
// The input is stalled while a division runs or a result waits for a full
// output register. The output register lets the next word in while a result
// is still stalled. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_rate_meter
  import srm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              button_level_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [RateW-1:0]       stroke_rate_o,
  output logic [CountW-1:0]      stroke_count_o,
  output logic [ModeW-1:0]       meter_mode_o,
  input  wire logic              cfg_we_i,
  input  wire logic [TicksW-1:0] cfg_wdata_i
);

  srm_state_e state_q, state_d;

  logic [TicksW-1:0] timeout_q;
  logic              prev_q, prev_d;
  logic              half_q, half_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic              have_prev_q, have_prev_d;
  logic [RateW-1:0]  rate_q, rate_d;
  logic [ModeW-1:0]  mode_q, mode_d;

  logic              out_valid_q, out_valid_d;
  logic [RateW-1:0]  out_rate_q, out_rate_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic [ModeW-1:0]  out_mode_q, out_mode_d;

  logic              accept;
  logic              slot_free;
  logic              rise;
  logic              need_div;
  logic [TicksW-1:0] div_dvs;
  logic              div_done;
  logic [RateW-1:0]  div_quo;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign rise       = button_level_i && !prev_q;

  // tick update, all but the rate which may need the divider
  always_comb begin
    prev_d      = prev_q;
    half_d      = half_q;
    count_d     = count_q;
    ticks_d     = ticks_q;
    have_prev_d = have_prev_q;
    mode_d      = mode_q;
    need_div    = 1'b0;
    div_dvs     = '0;
    if (accept) begin
      if (ticks_q != TicksMax) begin
        ticks_d = ticks_q + 1'b1;
      end
      if (rise) begin
        if (mode_q != ModeRunning) begin
          ticks_d = '0;
        end
        mode_d = ModeRunning;
        if (!half_q) begin
          count_d = count_q + 1'b1;
          if (have_prev_q && (ticks_d != '0)) begin
            need_div = 1'b1;
            div_dvs  = ticks_d;
          end
          ticks_d     = '0;
          have_prev_d = 1'b1;
        end
        half_d = !half_q;
      end
      if ((mode_d == ModeRunning) && (ticks_d >= timeout_q)) begin
        mode_d      = ModePaused;
        count_d     = '0;
        ticks_d     = '0;
        have_prev_d = 1'b0;
      end
      prev_d = button_level_i;
    end
  end

  srm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (need_div),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer and output register
  always_comb begin
    state_d     = state_q;
    rate_d      = rate_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rate_d  = out_rate_q;
    out_count_d = out_count_q;
    out_mode_d  = out_mode_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (need_div) begin
            state_d = ST_DIV;
          end else if (slot_free) begin
            out_valid_d = 1'b1;
            out_rate_d  = rate_q;
            out_count_d = count_d;
            out_mode_d  = mode_d;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          rate_d = div_quo;
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_rate_d  = div_quo;
            out_count_d = count_q;
            out_mode_d  = mode_q;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_rate_d  = rate_q;
          out_count_d = count_q;
          out_mode_d  = mode_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= TimeoutReset;
      prev_q      <= 1'b0;
      half_q      <= 1'b0;
      count_q     <= '0;
      ticks_q     <= '0;
      have_prev_q <= 1'b0;
      rate_q      <= '0;
      mode_q      <= ModeOff;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      prev_q      <= prev_d;
      half_q      <= half_d;
      count_q     <= count_d;
      ticks_q     <= ticks_d;
      have_prev_q <= have_prev_d;
      rate_q      <= rate_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rate_q  <= out_rate_d;
    out_count_q <= out_count_d;
    out_mode_q  <= out_mode_d;
  end

  assign out_valid_o    = out_valid_q;
  assign stroke_rate_o  = out_rate_q;
  assign stroke_count_o = out_count_q;
  assign meter_mode_o   = out_mode_q;

endmodule

`default_nettype wire

// ----- tb/sv/srm_meter_checker.sv -----
// ----------------------------------------------------------------------------
// srm_meter_checker
// Watches the tick, result and register ports of the stroke rate meter, keeps
// its own copy of the meter state, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module srm_meter_checker
  import srm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic              button_level_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic [RateW-1:0]  stroke_rate_i,
  input  wire logic [CountW-1:0] stroke_count_i,
  input  wire logic [ModeW-1:0]  meter_mode_i,
  input  wire logic              cfg_we_i,
  input  wire logic [TicksW-1:0] cfg_wdata_i,
  output int unsigned            awaited_o,
  output int unsigned            failures_o,
  output int unsigned            words_o,
  output int unsigned            rate_updates_o,
  output int unsigned            pauses_o
);

  typedef struct packed {
    logic [RateW-1:0]  rate;
    logic [CountW-1:0] count;
    logic [ModeW-1:0]  mode;
  } meter_reading_t;

  meter_reading_t awaited_readings[$];

  // meter state as the block should hold it
  logic [TicksW-1:0] timeout_ticks;
  logic              level_prev;
  logic              second_press;
  logic [CountW-1:0] strokes;
  logic [TicksW-1:0] since_stroke;
  logic              have_earlier;
  logic [RateW-1:0]  rate;
  logic [ModeW-1:0]  mode;

  int unsigned fails;
  int unsigned words;
  int unsigned rate_updates;
  int unsigned pauses;

  task automatic advance_meter(input logic level, output meter_reading_t reading);
    logic [31:0] quotient;
    if (since_stroke != TicksMax) since_stroke = since_stroke + 1'b1;
    if (level && !level_prev) begin
      // a press from off or paused restarts the timeout window
      if (mode != ModeRunning) since_stroke = '0;
      mode = ModeRunning;
      if (!second_press) begin
        strokes = strokes + 1'b1;
        if (have_earlier && since_stroke != '0) begin
          quotient = 32'(RateNumerator) / 32'(since_stroke);
          rate = quotient[RateW-1:0];
          rate_updates++;
        end
        since_stroke = '0;
        have_earlier = 1'b1;
      end
      second_press = ~second_press;
    end
    if (mode == ModeRunning && since_stroke >= timeout_ticks) begin
      mode = ModePaused;
      strokes = '0;
      since_stroke = '0;
      have_earlier = 1'b0;
      pauses++;
    end
    level_prev = level;
    reading = '{rate: rate, count: strokes, mode: mode};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    meter_reading_t want;
    meter_reading_t got;
    if (!rst_ni) begin
      timeout_ticks = TimeoutReset;
      level_prev    = 1'b0;
      second_press  = 1'b0;
      strokes       = '0;
      since_stroke  = '0;
      have_earlier  = 1'b0;
      rate          = '0;
      mode          = ModeOff;
      fails         = 0;
      words         = 0;
      rate_updates  = 0;
      pauses        = 0;
      awaited_readings.delete();
      awaited_o      <= 0;
      failures_o     <= 0;
      words_o        <= 0;
      rate_updates_o <= 0;
      pauses_o       <= 0;
    end else begin
      if (cfg_we_i) timeout_ticks = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        advance_meter(button_level_i, want);
        awaited_readings.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{rate: stroke_rate_i, count: stroke_count_i, mode: meter_mode_i};
        words++;
        if (awaited_readings.size() == 0) begin
          $error("result word with nothing awaited: rate %0d count %0d mode %0d",
                 got.rate, got.count, got.mode);
          fails++;
        end else begin
          want = awaited_readings.pop_front();
          if (got.rate !== want.rate) begin
            $error("stroke_rate: expected %0d, got %0d", want.rate, got.rate);
            fails++;
          end
          if (got.count !== want.count) begin
            $error("stroke_count: expected %0d, got %0d", want.count, got.count);
            fails++;
          end
          if (got.mode !== want.mode) begin
            $error("meter_mode: expected %0d, got %0d", want.mode, got.mode);
            fails++;
          end
        end
      end
      awaited_o      <= awaited_readings.size();
      failures_o     <= fails;
      words_o        <= words;
      rate_updates_o <= rate_updates;
      pauses_o       <= pauses;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives button ticks and timeout settings into the stroke rate meter with
// random gaps and output stalls; a checker beside the block predicts and
// compares every result word. Covers directed presses, both timeout extremes
// and randomised stroke sequences with noise.
// ----------------------------------------------------------------------------
module testbench;
  import srm_pkg::*;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              button_level_i = 1'b0;
  logic              out_stall_i    = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [TicksW-1:0] cfg_wdata_i    = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [RateW-1:0]  stroke_rate_o;
  logic [CountW-1:0] stroke_count_o;
  logic [ModeW-1:0]  meter_mode_o;

  logic        jitter_en = 1'b1;
  int unsigned awaited;
  int unsigned failures;
  int unsigned words;
  int unsigned rate_updates;
  int unsigned pauses;
  int unsigned settings_used = 1;

  logic [TicksW-1:0] timeouts[11] = '{16'd0, 16'd1, 16'd2, 16'd4, 16'd7, 16'd12,
                                      16'd25, 16'd60, 16'd300, 16'hFFFF, 16'd3};

  always #5 clk_i = ~clk_i;

  stroke_rate_meter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .stroke_rate_o  (stroke_rate_o),
    .stroke_count_o (stroke_count_o),
    .meter_mode_o   (meter_mode_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  srm_meter_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .button_level_i (button_level_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .stroke_rate_i  (stroke_rate_o),
    .stroke_count_i (stroke_count_o),
    .meter_mode_i   (meter_mode_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .awaited_o      (awaited),
    .failures_o     (failures),
    .words_o        (words),
    .rate_updates_o (rate_updates),
    .pauses_o       (pauses)
  );

  always @(posedge clk_i) begin
    out_stall_i <= jitter_en && ($urandom_range(99) < 23);
  end

  // valid stays high between back-to-back words; it drops only in a gap
  task automatic send_level(input logic level);
    while (jitter_en && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_level_i <= level;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic press(input int held, input int released);
    repeat (held) send_level(1'b1);
    repeat (released) send_level(1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited != 0);
  endtask

  task automatic set_timeout(input logic [TicksW-1:0] value);
    drain();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // mostly well-formed presses sized to the timeout, some raw noise
  task automatic random_phase(input int budget, input int unsigned limit);
    int sent;
    int n;
    int held;
    int gap;
    int kind;
    int unsigned gap_max;
    sent    = 0;
    gap_max = (limit > 32) ? 32 : limit + 3;
    while (sent < budget) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        n = $urandom_range(6, 1);
        repeat (n) send_level(1'($urandom_range(1)));
        sent += n;
      end else begin
        held = $urandom_range(3, 1);
        gap  = (kind < 30) ? $urandom_range(gap_max + 8, gap_max)
                           : $urandom_range(gap_max, 1);
        press(held, gap);
        sent += held + gap;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first press, held button, uncounted second press, strokes with rates
    press(2, 1);
    press(1, 2);
    press(1, 1);
    press(1, 3);
    press(3, 1);
    press(1, 1);

    // long strokes under the reset-value timeout, no gaps or stalls
    jitter_en <= 1'b0;
    press(1, 40);
    press(1, 2);
    press(1, 60);
    press(1, 2);
    jitter_en <= 1'b1;
    random_phase(70, TimeoutReset);

    foreach (timeouts[i]) begin
      set_timeout(timeouts[i]);
      random_phase(70, timeouts[i]);
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Checked %0d result words over %0d timeout settings: %0d rate updates, %0d pauses.",
             words, settings_used, rate_updates, pauses);
    if (failures == 0) begin
      $display("[stroke_rate_meter] OK");
    end else begin
      $display("[stroke_rate_meter] ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("[stroke_rate_meter] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/srm_pkg.sv
rtl/srm_div.sv
rtl/stroke_rate_meter.sv
tb/sv/srm_meter_checker.sv
tb/sv/testbench.sv
